FILE: design/gbga_pkg.sv
// Package for the GB2312 / ASCII glyph addresser.
// Holds byte-range constants, address constants and the shared struct types.
// No dependencies.
package gbga_pkg;

    localparam logic [7:0]  SYM_LEAD_LO  = 8'hA1;
    localparam logic [7:0]  SYM_LEAD_HI  = 8'hA3;
    localparam logic [7:0]  HZ_LEAD_LO   = 8'hB0;
    localparam logic [7:0]  HZ_LEAD_HI   = 8'hF7;
    localparam logic [7:0]  TRAIL_LO     = 8'hA1;
    localparam logic [7:0]  ASCII_LO     = 8'h20;
    localparam logic [7:0]  ASCII_HI     = 8'h7E;
    localparam logic [7:0]  ROW_CELLS    = 8'd94;
    localparam logic [12:0] HZ_OFFSET    = 13'd846;
    localparam logic [17:0] ASCII_BASE   = 18'h3CF80;
    localparam logic [7:0]  WIDE_STEP    = 8'd16;
    localparam logic [7:0]  NARROW_STEP  = 8'd8;
    localparam logic        CMD_BEGIN    = 1'b0;
    localparam logic        CMD_TEXT     = 1'b1;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic       lead_pending;
        logic [7:0] cursor_column;
        logic [3:0] cursor_page;
        logic       string_ended;
    } t_state;

    typedef struct packed {
        logic        emit;
        logic [17:0] font_address;
        logic        glyph_wide;
        logic [7:0]  glyph_column;
        logic [3:0]  glyph_page;
    } t_result;

endpackage

FILE: design/gbga_decode.sv
// Combinational decode of one item against the current cursor and lead state.
// Produces the next state and the glyph result, if any. Depends on gbga_pkg.
module gbga_decode
    import gbga_pkg::*;
(
    input  logic       i_command,
    input  logic [7:0] i_char_byte,
    input  logic [7:0] i_start_column,
    input  logic [3:0] i_start_page,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    logic        w_is_lead;
    logic        w_is_ascii;
    logic        w_is_hz;
    logic [6:0]  w_row;
    logic [13:0] w_row_base;
    logic [12:0] w_index;
    logic [7:0]  w_trail;
    logic [17:0] w_wide_addr;
    logic [17:0] w_narrow_addr;
    logic [7:0]  w_ascii_off;
    logic        w_fresh;

    always_comb begin
        w_is_lead = ((i_char_byte >= SYM_LEAD_LO) && (i_char_byte <= SYM_LEAD_HI)) ||
                    ((i_char_byte >= HZ_LEAD_LO) && (i_char_byte <= HZ_LEAD_HI));
        w_is_ascii = (i_char_byte >= ASCII_LO) && (i_char_byte <= ASCII_HI);
        w_is_hz = (i_state.lead_byte >= HZ_LEAD_LO);
        w_row = w_is_hz ? 7'(i_state.lead_byte - HZ_LEAD_LO)
                        : 7'(i_state.lead_byte - SYM_LEAD_LO);
        w_row_base = 14'(w_row) * 14'(ROW_CELLS);
        w_trail = i_char_byte - TRAIL_LO;
        w_index = 13'(w_row_base) + 13'(w_trail) + (w_is_hz ? HZ_OFFSET : 13'd0);
        w_wide_addr = {w_index, 5'd0};
        w_ascii_off = i_char_byte - ASCII_LO;
        w_narrow_addr = ASCII_BASE + {6'd0, w_ascii_off, 4'd0};

        o_state = i_state;
        o_result.emit = 1'b0;
        o_result.font_address = w_narrow_addr;
        o_result.glyph_wide = 1'b0;
        o_result.glyph_column = i_state.cursor_column;
        o_result.glyph_page = i_state.cursor_page;
        w_fresh = 1'b0;

        if (i_command == CMD_BEGIN) begin
            o_state.cursor_column = i_start_column;
            o_state.cursor_page = i_start_page;
            o_state.lead_pending = 1'b0;
            o_state.lead_byte = 8'd0;
            o_state.string_ended = 1'b0;
        end else if (!i_state.string_ended) begin
            if (i_char_byte == 8'd0) begin
                o_state.lead_pending = 1'b0;
                o_state.string_ended = 1'b1;
            end else begin
                w_fresh = 1'b1;
                if (i_state.lead_pending) begin
                    o_state.lead_pending = 1'b0;
                    if (i_char_byte >= TRAIL_LO) begin
                        w_fresh = 1'b0;
                        o_result.emit = 1'b1;
                        o_result.glyph_wide = 1'b1;
                        o_result.font_address = w_wide_addr;
                        o_state.cursor_column = i_state.cursor_column + WIDE_STEP;
                    end
                end
                if (w_fresh) begin
                    if (w_is_lead) begin
                        o_state.lead_byte = i_char_byte;
                        o_state.lead_pending = 1'b1;
                    end else if (w_is_ascii) begin
                        o_result.emit = 1'b1;
                        o_state.cursor_column = i_state.cursor_column + NARROW_STEP;
                    end
                end
            end
        end
    end

endmodule

FILE: design/gb2312_ascii_glyph_addresser.sv
// Top level of the GB2312 / ASCII glyph addresser.
// Depends on gbga_pkg and gbga_decode.
//
// The input channel (i_in_valid / o_in_ready) carries one item per transfer:
// a begin item (command 0) that sets the start column and page, or a text
// byte (command 1). A zero byte closes the string; bytes arriving with no
// open string are dropped.
// The output channel (o_out_valid / i_out_ready) carries one glyph item:
// the font ROM byte address, the glyph width flag, and the column and page
// at which the glyph is drawn. Wide GB2312 glyphs advance the column by 16,
// ASCII glyphs by 8, with wraparound at 256.
// Each input item is decoded in the cycle it is accepted, and its glyph, if
// any, appears on the output in the next cycle. One item is accepted per
// cycle while the receiver does not stall; the single output register sets
// that rate, since a new item is taken whenever that register is empty or
// being drained in the same cycle. When the receiver stalls with a glyph held,
// o_in_ready drops until the glyph is taken.
// Reset clears the output valid, drops any held lead byte, sets the cursor
// to column 0, page 1, and marks the string as closed.
module gb2312_ascii_glyph_addresser
    import gbga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_char_byte,
    input  logic [7:0]  i_start_column,
    input  logic [3:0]  i_start_page,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [17:0] o_font_address,
    output logic        o_glyph_wide,
    output logic [7:0]  o_glyph_column,
    output logic [3:0]  o_glyph_page
);

    t_state  r_state;
    t_state  n_state;
    t_result w_result;
    logic    r_out_valid;
    logic    w_accept;
    logic [17:0] r_font_address;
    logic        r_glyph_wide;
    logic [7:0]  r_glyph_column;
    logic [3:0]  r_glyph_page;

    gbga_decode u_decode (
        .i_command      (i_command),
        .i_char_byte    (i_char_byte),
        .i_start_column (i_start_column),
        .i_start_page   (i_start_page),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result       (w_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.lead_byte <= 8'd0;
            r_state.lead_pending <= 1'b0;
            r_state.cursor_column <= 8'd0;
            r_state.cursor_page <= 4'd1;
            r_state.string_ended <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
                r_out_valid <= w_result.emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_result.emit) begin
            r_font_address <= w_result.font_address;
            r_glyph_wide <= w_result.glyph_wide;
            r_glyph_column <= w_result.glyph_column;
            r_glyph_page <= w_result.glyph_page;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_font_address = r_font_address;
    assign o_glyph_wide = r_glyph_wide;
    assign o_glyph_column = r_glyph_column;
    assign o_glyph_page = r_glyph_page;

endmodule

FILE: design/gbga_checker.sv
// Port-level checker for the glyph addresser, bound to the top level.
// Depends on gbga_pkg for the ASCII glyph base address.
module gbga_checker
    import gbga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [17:0] o_font_address,
    input  logic        o_glyph_wide
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_font_address))
        else $error("Stalled glyph item changed or vanished.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled while the output register is empty.");

    a_wide_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_glyph_wide |-> o_font_address[4:0] == 5'd0
            && o_font_address < ASCII_BASE)
        else $error("Wide glyph address is misaligned or out of range.");

    a_narrow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_glyph_wide |-> o_font_address >= ASCII_BASE
            && o_font_address[3:0] == 4'd0)
        else $error("Narrow glyph address is outside the ASCII area.");

endmodule

bind gb2312_ascii_glyph_addresser gbga_checker u_gbga_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_font_address (o_font_address),
    .o_glyph_wide   (o_glyph_wide)
);

FILE: bench/gb2312_ascii_glyph_addresser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for gb2312_ascii_glyph_addresser: sends begin items and text bytes,
// predicts each glyph address and position, and checks every output item in order.
// Depends on gbga_pkg and the gb2312_ascii_glyph_addresser design.
module gb2312_ascii_glyph_addresser_test;
    import gbga_pkg::*;

    localparam int MISMATCH_SHOWN  = 10;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 1420;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic [17:0] font_address;
        logic        glyph_wide;
        logic [7:0]  glyph_column;
        logic [3:0]  glyph_page;
    } t_glyph;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [7:0]  i_char_byte;
    logic [7:0]  i_start_column;
    logic [3:0]  i_start_page;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [17:0] o_font_address;
    logic        o_glyph_wide;
    logic [7:0]  o_glyph_column;
    logic [3:0]  o_glyph_page;

    logic [7:0]  held_lead;
    logic        lead_held;
    logic [7:0]  cursor_col;
    logic [3:0]  cursor_pg;
    logic        string_closed;
    t_glyph      pending_glyphs[$];

    bit          pace_gaps;
    int          hold_left;
    int          out_stall;
    int          quiet_cycles;
    int          items_sent;
    int          glyphs_checked;
    int          mismatches;

    gb2312_ascii_glyph_addresser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_char_byte    (i_char_byte),
        .i_start_column (i_start_column),
        .i_start_page   (i_start_page),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_font_address (o_font_address),
        .o_glyph_wide   (o_glyph_wide),
        .o_glyph_column (o_glyph_column),
        .o_glyph_page   (o_glyph_page)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic push_glyph(input int unsigned addr, input logic wide);
        t_glyph g;
        g.font_address = addr[17:0];
        g.glyph_wide   = wide;
        g.glyph_column = cursor_col;
        g.glyph_page   = cursor_pg;
        pending_glyphs.push_back(g);
        cursor_col = cursor_col + (wide ? 8'd16 : 8'd8);
    endtask

    task automatic predict_glyph(input logic cmd, input logic [7:0] b,
                                 input logic [7:0] col, input logic [3:0] pg);
        int unsigned idx;
        bit          fresh;
        if (cmd == CMD_BEGIN) begin
            cursor_col    = col;
            cursor_pg     = pg;
            lead_held     = 1'b0;
            held_lead     = 8'h00;
            string_closed = 1'b0;
        end else if (!string_closed) begin
            fresh = 1'b1;
            if (b == 8'h00) begin
                lead_held     = 1'b0;
                string_closed = 1'b1;
                fresh         = 1'b0;
            end else if (lead_held) begin
                lead_held = 1'b0;
                if (b >= 8'hA1) begin
                    if (held_lead >= 8'hB0)
                        idx = (int'(held_lead) - 'hB0) * 94 + (int'(b) - 'hA1) + 846;
                    else
                        idx = (int'(held_lead) - 'hA1) * 94 + (int'(b) - 'hA1);
                    push_glyph(idx * 32, 1'b1);
                    fresh = 1'b0;
                end
            end
            if (fresh) begin
                if ((b >= 8'hA1 && b <= 8'hA3) || (b >= 8'hB0 && b <= 8'hF7)) begin
                    held_lead = b;
                    lead_held = 1'b1;
                end else if (b >= 8'h20 && b <= 8'h7E) begin
                    push_glyph((int'(b) - 'h20) * 16 + 'h3CF80, 1'b0);
                end
            end
        end
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] b,
                             input logic [7:0] col, input logic [3:0] pg);
        int gap;
        gap = pace_gaps ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_command      = cmd;
        i_char_byte    = b;
        i_start_column = col;
        i_start_page   = pg;
        do @(posedge i_clk); while (!o_in_ready);
        predict_glyph(cmd, b, col, pg);
        items_sent++;
    endtask

    task automatic send_text(input logic [7:0] b);
        send_item(CMD_TEXT, b, 8'($urandom), 4'($urandom));
    endtask

    task automatic send_begin(input logic [7:0] col, input logic [3:0] pg);
        send_item(CMD_BEGIN, 8'($urandom), col, pg);
    endtask

    task automatic test_closed_string();
        send_text(8'h41);
        send_text(8'hB0);
        send_text(8'hA1);
        send_text(8'h00);
    endtask

    task automatic test_directed();
        byte unsigned seq[] = '{8'h20, 8'h7E, 8'h1F, 8'h7F, 8'hA4, 8'hA1, 8'hA1, 8'hA3,
                                8'hFE, 8'hB0, 8'hA1, 8'hF7, 8'hFE, 8'hB5, 8'h41, 8'hC0,
                                8'h05, 8'hB0, 8'hB0, 8'hA2, 8'h00, 8'h5A};
        send_begin(8'd0, 4'd1);
        foreach (seq[i])
            send_text(seq[i]);
        send_begin(8'd250, 4'd9);
        send_text(8'h57);
        send_text(8'hD0);
        send_begin(8'd255, 4'd0);
        send_text(8'h61);
        send_text(8'h00);
    endtask

    task automatic send_random_string();
        int len;
        int pick;
        if ($urandom_range(0, 99) < 80)
            send_begin(8'($urandom_range(0, 131)),
                       ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 9)) : 4'($urandom));
        else
            send_begin(8'($urandom), 4'($urandom));
        len = $urandom_range(1, 24);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_text(8'($urandom_range('h20, 'h7E)));
            end else if (pick < 75) begin
                send_text(($urandom_range(0, 99) < 30) ? 8'($urandom_range('hA1, 'hA3))
                                                       : 8'($urandom_range('hB0, 'hF7)));
                send_text(8'($urandom_range('hA1, 'hFF)));
            end else if (pick < 85) begin
                send_text(8'($urandom_range('hB0, 'hF7)));
                send_text(8'($urandom_range('h01, 'hA0)));
            end else begin
                send_text(8'($urandom));
            end
        end
        if ($urandom_range(0, 99) < 85)
            send_text(8'h00);
        if ($urandom_range(0, 99) < 10)
            send_text(8'($urandom));
    endtask

    task automatic test_back_to_back();
        pace_gaps = 1'b0;
        repeat (6)
            send_random_string();
        pace_gaps = 1'b1;
    endtask

    task automatic test_receiver_hold();
        send_begin(8'd16, 4'd3);
        hold_left = HOLD_OFF_CYCLES;
        repeat (30)
            send_text(8'($urandom_range('h20, 'h7E)));
        send_text(8'h00);
    endtask

    task automatic test_random_strings();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) == 0)
                pace_gaps = !pace_gaps;
            send_random_string();
        end
        pace_gaps = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else if (out_stall > 0) begin
            i_out_ready = 1'b0;
            out_stall--;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_glyph got;
        t_glyph want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_font_address, o_glyph_wide, o_glyph_column, o_glyph_page};
            out_stall = pace_gaps ? $urandom_range(0, 4) : 0;
            glyphs_checked++;
            if (pending_glyphs.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN)
                    $display("Unexpected glyph item: addr %h wide %0d col %0d page %0d",
                             got.font_address, got.glyph_wide, got.glyph_column,
                             got.glyph_page);
            end else begin
                want = pending_glyphs.pop_front();
                if (got.font_address !== want.font_address || got.glyph_wide !== want.glyph_wide
                    || got.glyph_column !== want.glyph_column
                    || got.glyph_page !== want.glyph_page) begin
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOWN) begin
                        $display("Glyph mismatch: expected addr %h wide %0d col %0d page %0d,",
                                 want.font_address, want.glyph_wide, want.glyph_column,
                                 want.glyph_page);
                        $display("    got addr %h wide %0d col %0d page %0d",
                                 got.font_address, got.glyph_wide, got.glyph_column,
                                 got.glyph_page);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout with %0d glyph items outstanding.", pending_glyphs.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_TEXT;
        i_char_byte    = 8'h00;
        i_start_column = 8'h00;
        i_start_page   = 4'h0;
        i_out_ready    = 1'b0;
        pace_gaps      = 1'b1;
        hold_left      = 0;
        out_stall      = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        glyphs_checked = 0;
        mismatches     = 0;
        held_lead      = 8'h00;
        lead_held      = 1'b0;
        cursor_col     = 8'd0;
        cursor_pg      = 4'd1;
        string_closed  = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_closed_string();
        test_directed();
        test_back_to_back();
        test_receiver_hold();
        test_random_strings();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (begin items, ASCII, GB2312 pairs, broken leads, noise).",
                 items_sent);
        $display("Checked %0d glyph items under random gaps, back-to-back runs and a long stall.",
                 glyphs_checked);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
design/gbga_pkg.sv
design/gbga_decode.sv
design/gb2312_ascii_glyph_addresser.sv
design/gbga_checker.sv
bench/gb2312_ascii_glyph_addresser_test.sv
